// ===== hw/rtl/tib_pkg.sv =====
// ============================================================================
// tib_pkg
// Shared types, constants and the control program of the TLB invalidate
// batcher.
// ============================================================================
package tib_pkg;

    localparam int MAX_RANGES = 16;
    localparam int COST_LIMIT = 64;
    localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int PAGES_W    = 7;
    localparam int SHIFT_W    = 5;
    localparam int ADDR_W     = 64;
    localparam int COST_W     = 8;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_CLEAR  = 2'd0;
    localparam t_cmd CMD_ADD    = 2'd1;
    localparam t_cmd CMD_COMMIT = 2'd2;
    localparam t_cmd CMD_UNUSED = 2'd3;

    typedef logic [1:0] t_action;
    localparam t_action ACT_INVAL  = 2'd0;
    localparam t_action ACT_RELOAD = 2'd1;
    localparam t_action ACT_TOGGLE = 2'd2;
    localparam t_action ACT_NONE   = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [PAGES_W-1:0] pages;
        logic [SHIFT_W-1:0] shift;
    } t_range;

    typedef logic [3:0] t_step;
    localparam t_step ST_IDLE   = 4'd0;
    localparam t_step ST_ADD    = 4'd1;
    localparam t_step ST_COMMIT = 4'd2;
    localparam t_step ST_FETCH  = 4'd3;
    localparam t_step ST_LOAD   = 4'd4;
    localparam t_step ST_EMIT   = 4'd5;
    localparam t_step ST_NEXT   = 4'd6;
    localparam t_step ST_CLEAR  = 4'd7;
    localparam t_step ST_SINGLE = 4'd8;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_ADD    = 3'd1,
        OP_CSTART = 3'd2,
        OP_LOAD   = 3'd3,
        OP_EMIT   = 3'd4,
        OP_NEXT   = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_SINGLE = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        BR_NEXT     = 2'd0,
        BR_GOTO     = 2'd1,
        BR_COND     = 2'd2,
        BR_DISPATCH = 2'd3
    } t_br;

    typedef enum logic [1:0] {
        COND_SINGLE      = 2'd0,
        COND_NOPAGE      = 2'd1,
        COND_MORE_PAGES  = 2'd2,
        COND_MORE_RANGES = 2'd3
    } t_cond;

    typedef enum logic {
        RD_LAST = 1'b0,
        RD_IDX  = 1'b1
    } t_rd_sel;

    typedef struct packed {
        logic    accept;
        logic    emit;
        t_op     op;
        t_rd_sel rd_sel;
        t_br     br;
        t_cond   cond;
        t_step   target;
    } t_cword;

    typedef struct packed {
        logic    fire;
        t_op     op;
        t_rd_sel rd_sel;
    } t_ctrl;

    typedef struct packed {
        logic out_free;
        logic single;
        logic nopage;
        logic more_pages;
        logic more_ranges;
    } t_status;

    function automatic t_cword ucode_rom(input t_step step);
        t_cword cw;
        cw = '{accept: 1'b0, emit: 1'b0, op: OP_NONE, rd_sel: RD_LAST,
               br: BR_GOTO, cond: COND_SINGLE, target: ST_IDLE};
        case (step)
            ST_IDLE: begin
                cw.accept = 1'b1;
                cw.br     = BR_DISPATCH;
            end
            ST_ADD: begin
                cw.op = OP_ADD;
            end
            ST_COMMIT: begin
                cw.op     = OP_CSTART;
                cw.br     = BR_COND;
                cw.cond   = COND_SINGLE;
                cw.target = ST_SINGLE;
            end
            ST_FETCH: begin
                cw.rd_sel = RD_IDX;
                cw.br     = BR_NEXT;
            end
            ST_LOAD: begin
                cw.op     = OP_LOAD;
                cw.br     = BR_COND;
                cw.cond   = COND_NOPAGE;
                cw.target = ST_NEXT;
            end
            ST_EMIT: begin
                cw.emit   = 1'b1;
                cw.op     = OP_EMIT;
                cw.br     = BR_COND;
                cw.cond   = COND_MORE_PAGES;
                cw.target = ST_EMIT;
            end
            ST_NEXT: begin
                cw.op     = OP_NEXT;
                cw.br     = BR_COND;
                cw.cond   = COND_MORE_RANGES;
                cw.target = ST_FETCH;
            end
            ST_CLEAR: begin
                cw.op = OP_CLEAR;
            end
            ST_SINGLE: begin
                cw.emit   = 1'b1;
                cw.op     = OP_SINGLE;
                cw.target = ST_CLEAR;
            end
            default: begin
                cw.target = ST_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== hw/rtl/tib_ram.sv =====
// ============================================================================
// tib_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module tib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tib_sequencer.sv =====
// ============================================================================
// tib_sequencer
// Step counter and control store; fetches one control word per step and
// resolves dispatch and conditional jumps.
// ============================================================================
module tib_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  tib_pkg::t_cmd    i_cmd,
    input  tib_pkg::t_status i_status,
    output tib_pkg::t_ctrl   o_ctrl,
    output logic             o_in_ready
);
    import tib_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_cword w_cw;
    logic   w_fire;
    logic   w_cond;

    always_comb begin
        w_cw   = ucode_rom(r_step);
        w_fire = !(w_cw.emit && !i_status.out_free);
        unique case (w_cw.cond)
            COND_SINGLE:      w_cond = i_status.single;
            COND_NOPAGE:      w_cond = i_status.nopage;
            COND_MORE_PAGES:  w_cond = i_status.more_pages;
            COND_MORE_RANGES: w_cond = i_status.more_ranges;
            default:          w_cond = 1'b0;
        endcase
        n_step = r_step;
        if (w_fire) begin
            unique case (w_cw.br)
                BR_NEXT: n_step = r_step + t_step'(1);
                BR_GOTO: n_step = w_cw.target;
                BR_COND: n_step = w_cond ? w_cw.target : r_step + t_step'(1);
                BR_DISPATCH: begin
                    if (i_in_valid) begin
                        unique case (i_cmd)
                            CMD_CLEAR:  n_step = ST_CLEAR;
                            CMD_ADD:    n_step = ST_ADD;
                            CMD_COMMIT: n_step = ST_COMMIT;
                            default:    n_step = ST_IDLE;
                        endcase
                    end
                end
                default: n_step = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_in_ready = w_cw.accept;
    assign o_ctrl     = '{fire: w_fire, op: w_cw.op, rd_sel: w_cw.rd_sel};

endmodule

// ===== hw/rtl/tib_datapath.sv =====
// ============================================================================
// tib_datapath
// Batch registers, range store, page walker and output register, driven by
// the control word of the sequencer.
// ============================================================================
module tib_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tib_pkg::t_ctrl                 i_ctrl,
    input  logic                           i_in_accept,
    input  logic [tib_pkg::ADDR_W-1:0]     i_vaddr,
    input  logic [tib_pkg::PAGES_W-1:0]    i_page_count,
    input  logic [tib_pkg::SHIFT_W-1:0]    i_page_shift,
    input  logic                           i_global_page,
    input  logic                           i_out_ready,
    output tib_pkg::t_status               o_status,
    output logic                           o_out_valid,
    output tib_pkg::t_action               o_action,
    output logic [tib_pkg::ADDR_W-1:0]     o_page_addr,
    output logic                           o_last
);
    import tib_pkg::*;

    logic [ADDR_W-1:0]  r_vaddr;
    logic [PAGES_W-1:0] r_pages;
    logic [SHIFT_W-1:0] r_shift;
    logic               r_glob;

    logic [CNT_W-1:0]   r_count;
    logic [COST_W-1:0]  r_cost;
    logic               r_full;
    logic               r_fglob;
    logic [PAGES_W-1:0] r_total;
    logic [IDX_W-1:0]   r_idx;
    logic [PAGES_W-1:0] r_emitted;

    logic [ADDR_W-1:0]  r_cur;
    logic [PAGES_W-1:0] r_left;
    logic [SHIFT_W-1:0] r_cshift;

    logic               r_out_valid;
    t_action            r_out_action;
    logic [ADDR_W-1:0]  r_out_addr;
    logic               r_out_last;

    t_range             w_rd;
    t_range             w_wr;
    logic [IDX_W-1:0]   w_raddr;
    logic [IDX_W-1:0]   w_last_idx;
    logic [IDX_W-1:0]   w_waddr;
    logic               w_we;
    logic [PAGES_W-1:0] w_cost;
    logic [COST_W:0]    w_sum;
    logic [COST_W-1:0]  w_cost_new;
    logic               w_over;
    logic [ADDR_W-1:0]  w_end;
    logic               w_merge;
    logic               w_room;
    logic               w_out_free;
    logic               w_do;

    assign w_do       = i_ctrl.fire;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_last_idx = IDX_W'(r_count - CNT_W'(1));
    assign w_raddr    = (i_ctrl.rd_sel == RD_IDX) ? r_idx : w_last_idx;

    always_comb begin
        w_cost     = (r_pages == '0) ? PAGES_W'(1) : r_pages;
        w_sum      = {1'b0, r_cost} + (COST_W + 1)'(w_cost);
        w_cost_new = (w_sum > (COST_W + 1)'(255)) ? COST_W'(255) : w_sum[COST_W-1:0];
        w_over     = w_cost_new > COST_W'(COST_LIMIT);
        w_end      = w_rd.start + (ADDR_W'(w_rd.pages) << w_rd.shift);
        w_merge    = (r_count != '0) && (w_end == r_vaddr) && (w_rd.shift == r_shift);
        w_room     = r_count < CNT_W'(MAX_RANGES);
        w_we       = w_do && (i_ctrl.op == OP_ADD) && !r_full && !w_over
                     && (w_merge || w_room);
        w_waddr    = w_merge ? w_last_idx : IDX_W'(r_count);
        if (w_merge) begin
            w_wr = '{start: w_rd.start, pages: w_rd.pages + r_pages, shift: w_rd.shift};
        end else begin
            w_wr = '{start: r_vaddr, pages: r_pages, shift: r_shift};
        end
    end

    tib_ram #(
        .WIDTH ($bits(t_range)),
        .DEPTH (MAX_RANGES)
    ) u_ranges (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_vaddr <= i_vaddr;
            r_pages <= i_page_count;
            r_shift <= i_page_shift;
            r_glob  <= i_global_page;
        end
        if (w_do && i_ctrl.op == OP_LOAD) begin
            r_cur    <= w_rd.start;
            r_left   <= w_rd.pages;
            r_cshift <= w_rd.shift;
        end
        if (w_do && i_ctrl.op == OP_EMIT) begin
            r_cur  <= r_cur + (ADDR_W'(1) << r_cshift);
            r_left <= r_left - PAGES_W'(1);
        end
        if (w_do && i_ctrl.op == OP_EMIT) begin
            r_out_action <= ACT_INVAL;
            r_out_addr   <= r_cur;
            r_out_last   <= (r_emitted + PAGES_W'(1)) == r_total;
        end else if (w_do && i_ctrl.op == OP_SINGLE) begin
            r_out_action <= r_full ? (r_fglob ? ACT_TOGGLE : ACT_RELOAD) : ACT_NONE;
            r_out_addr   <= '0;
            r_out_last   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cost      <= '0;
            r_full      <= 1'b0;
            r_fglob     <= 1'b0;
            r_total     <= '0;
            r_idx       <= '0;
            r_emitted   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_do && (i_ctrl.op == OP_EMIT || i_ctrl.op == OP_SINGLE)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_do) begin
                case (i_ctrl.op)
                    OP_ADD: begin
                        if (!r_full) begin
                            r_fglob <= r_glob;
                            r_cost  <= w_cost_new;
                            if (w_over) begin
                                r_full <= 1'b1;
                            end else if (w_merge) begin
                                r_total <= r_total + r_pages;
                            end else if (w_room) begin
                                r_count <= r_count + CNT_W'(1);
                                r_total <= r_total + r_pages;
                            end else begin
                                r_full <= 1'b1;
                            end
                        end
                    end
                    OP_CSTART: begin
                        r_idx     <= '0;
                        r_emitted <= '0;
                    end
                    OP_EMIT: begin
                        r_emitted <= r_emitted + PAGES_W'(1);
                    end
                    OP_NEXT: begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                    OP_CLEAR: begin
                        r_count <= '0;
                        r_cost  <= '0;
                        r_full  <= 1'b0;
                        r_fglob <= 1'b0;
                        r_total <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_status = '{
        out_free:    w_out_free,
        single:      r_full || (r_total == '0),
        nopage:      w_rd.pages == '0,
        more_pages:  r_left != PAGES_W'(1),
        more_ranges: (CNT_W'(r_idx) + CNT_W'(1)) != r_count
    };

    assign o_out_valid = r_out_valid;
    assign o_action    = r_out_action;
    assign o_page_addr = r_out_addr;
    assign o_last      = r_out_last;

endmodule

// ===== hw/rtl/tlb_invalidate_batcher_unit.sv =====
// ============================================================================
// tlb_invalidate_batcher_unit
// Collects TLB invalidation ranges into a batch and, on commit, streams out
// one full-flush or no-op action, or one invalidate per page.
// ============================================================================
// Commands are taken one at a time. A clear runs the clear step, and an add
// runs the add step, which does one read-modify-write of the range store.
// A commit runs the commit step, then for each stored range a fetch, a load
// and a next step that read it from the range store and step past it, plus
// one emit step per page emitted, and the clear step to clear the batch at
// the end; a full flush or an empty batch runs only the commit, single and
// clear steps, its single result coming from the single step.
// The output register holds a result until it is taken, and the program
// stops while it is full.
module tlb_invalidate_batcher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: vaddr[63:0], page_count[70:64], page_shift[75:71],
    // global_page[76], zero[79:77]
    input  logic [79:0] s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: page_addr[63:0]
    output logic [63:0] m_axis_tdata,
    // tuser: action[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import tib_pkg::*;

    t_ctrl   w_ctrl;
    t_status w_status;
    logic    w_in_ready;
    logic    w_in_accept;

    assign w_in_accept   = s_axis_tvalid && w_in_ready;
    assign s_axis_tready = w_in_ready;

    tib_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_cmd      (s_axis_tuser),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl),
        .o_in_ready (w_in_ready)
    );

    tib_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_in_accept   (w_in_accept),
        .i_vaddr       (s_axis_tdata[63:0]),
        .i_page_count  (s_axis_tdata[70:64]),
        .i_page_shift  (s_axis_tdata[75:71]),
        .i_global_page (s_axis_tdata[76]),
        .i_out_ready   (m_axis_tready),
        .o_status      (w_status),
        .o_out_valid   (m_axis_tvalid),
        .o_action      (m_axis_tuser),
        .o_page_addr   (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

endmodule
